[rtl/core/assert_macros.svh]
// Assertion macros for the I2C register transfer RTL.
// No dependencies; SYNTHESIS drops the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_CHK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define AST_ALW(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define AST_CHK(lbl, clk_s, rst_s, prop, msg)
`define AST_ALW(lbl, clk_s, prop, msg)
`endif
`endif

[rtl/core/i2cmrt_pkg.sv]
// Types and constants for the I2C master register transfer block.
// No dependencies.
package i2cmrt_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_EVENT = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OUTCOME_NONE    = 2'd0,
    OUTCOME_OK      = 2'd1,
    OUTCOME_TIMEOUT = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    CFG_SLAVE_ADDR = 3'd0,
    CFG_REG_ADDR   = 3'd1,
    CFG_LENGTH     = 3'd2,
    CFG_READ_MODE  = 3'd3,
    CFG_TIMEOUT    = 3'd4
  } cfg_idx_t;

  // bus controller status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
  localparam logic [7:0] ST_TXDATA_ACK  = 8'h28;
  localparam logic [7:0] ST_TXDATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
  localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
  localparam logic [7:0] ST_RXDATA_NACK = 8'h58;
  localparam logic [7:0] READ_BIT       = 8'h01;

  localparam logic [5:0]  LENGTH_RST  = 6'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [7:0] bus_status;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_ack;
    logic       clear_irq;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] outcome;
  } out_item_t;

endpackage

[rtl/core/i2c_master_register_transfer.sv]
// I2C master register transfer sequencer, top level.
// Depends on i2cmrt_pkg and assert_macros.svh.
//
// Usage: configure slave address, register address, length, mode and timeout
// through the cfg_ write port (cfg_ready is always high) while idle. Load
// write bytes with func 0, start with func 1, then pass each bus status
// event (func 2) and timer ticks (func 3) on the in_ channel. Every accepted
// item yields exactly one result on the out_ channel with the bus control
// actions to apply.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while no stall holds a pending result; all
// decode is one pass from the state registers and the prefetched write buffer
// entry into the result register. The write buffer is a MAX_LENGTH entry
// memory whose registered read port always points at the next byte to send.
// Reset: control state clears, registers take their reset values; the
// buffer holds no valid data until loaded.
// Stall: when out_stall holds a pending result, in_stall is raised and the
// result register keeps its value while the stall lasts.
`include "assert_macros.svh"
module i2c_master_register_transfer
  import i2cmrt_pkg::*;
#(
  parameter int MAX_LENGTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PTR_W  = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W = $clog2(MAX_LENGTH);
  localparam int CMP_W  = ((PTR_W > 6) ? PTR_W : 6) + 1;

  logic [7:0]  slave_addr_r;
  logic [7:0]  reg_addr_r;
  logic [5:0]  length_r;
  logic        read_mode_r;
  logic [15:0] timeout_r;

  logic             busy_r, busy_nxt;
  logic [PTR_W-1:0] byte_index_r, byte_index_nxt;
  logic [PTR_W-1:0] load_ptr_r, load_ptr_nxt;
  logic [15:0]      ticks_left_r, ticks_left_nxt;

  logic [7:0] wbuf [MAX_LENGTH];
  logic [7:0] rd_data_r;
  logic       load_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      in_accept;

  logic [CMP_W-1:0] len_raw, eff_len, idx_w, idx_inc, idx_inc2, idx_after;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= '0;
      reg_addr_r   <= '0;
      length_r     <= LENGTH_RST;
      read_mode_r  <= 1'b0;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_data[7:0];
        CFG_REG_ADDR:   reg_addr_r   <= cfg_data[7:0];
        CFG_LENGTH:     length_r     <= cfg_data[5:0];
        CFG_READ_MODE:  read_mode_r  <= cfg_data[0];
        CFG_TIMEOUT:    timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_raw = CMP_W'(length_r);
    if (len_raw == '0) begin
      eff_len = CMP_W'(1);
    end else if (len_raw > CMP_W'(MAX_LENGTH)) begin
      eff_len = CMP_W'(MAX_LENGTH);
    end else begin
      eff_len = len_raw;
    end
    idx_w    = CMP_W'(byte_index_r);
    idx_inc  = idx_w + CMP_W'(1);
    idx_inc2 = idx_w + CMP_W'(2);
  end

  always_comb begin
    res            = '0;
    busy_nxt       = busy_r;
    byte_index_nxt = byte_index_r;
    load_ptr_nxt   = load_ptr_r;
    ticks_left_nxt = ticks_left_r;
    load_we        = 1'b0;
    idx_after      = idx_w;
    case (in_data.func)
      FUNC_LOAD: begin
        if (load_ptr_r < PTR_W'(MAX_LENGTH)) begin
          load_we      = 1'b1;
          load_ptr_nxt = load_ptr_r + PTR_W'(1);
        end
      end
      FUNC_BEGIN: begin
        if (!busy_r) begin
          busy_nxt       = 1'b1;
          byte_index_nxt = '0;
          ticks_left_nxt = timeout_r;
          load_ptr_nxt   = '0;
          res.set_start  = 1'b1;
        end
      end
      FUNC_EVENT: begin
        if (busy_r) begin
          res.clear_irq = 1'b1;
          if (!read_mode_r) begin
            unique case (in_data.bus_status)
              ST_START: begin
                res.clear_start = 1'b1;
                res.tx_valid    = 1'b1;
                res.tx_byte     = slave_addr_r;
              end
              ST_SLAW_ACK: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = reg_addr_r;
              end
              ST_TXDATA_ACK: begin
                if (idx_w < eff_len) begin
                  res.tx_valid   = 1'b1;
                  res.tx_byte    = rd_data_r;
                  byte_index_nxt = PTR_W'(idx_inc);
                end else begin
                  res.set_stop = 1'b1;
                  res.done_res = 1'b1;
                  res.outcome  = OUTCOME_OK;
                  busy_nxt     = 1'b0;
                end
              end
              ST_SLAW_NACK, ST_ARB_LOST: res.set_start = 1'b1;
              ST_TXDATA_NACK:            res.set_stop  = 1'b1;
              default: ;
            endcase
          end else begin
            unique case (in_data.bus_status)
              ST_START: begin
                res.clear_start = 1'b1;
                res.tx_valid    = 1'b1;
                res.tx_byte     = slave_addr_r;
              end
              ST_SLAW_ACK: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = reg_addr_r;
              end
              ST_TXDATA_ACK: res.set_start = 1'b1;
              ST_RSTART: begin
                res.clear_start = 1'b1;
                res.tx_valid    = 1'b1;
                res.tx_byte     = slave_addr_r | READ_BIT;
              end
              ST_SLAR_ACK: begin
                if (eff_len > CMP_W'(1)) res.set_ack = 1'b1;
                else res.clear_ack = 1'b1;
              end
              ST_RXDATA_ACK: begin
                if (idx_w < eff_len) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = in_data.data_byte;
                  idx_after    = idx_inc;
                  if (idx_inc2 == eff_len) res.clear_ack = 1'b1;
                end
              end
              ST_RXDATA_NACK: begin
                if (idx_w < eff_len) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = in_data.data_byte;
                  idx_after    = idx_inc;
                end
                res.set_stop = 1'b1;
              end
              ST_ARB_LOST: res.set_start = 1'b1;
              ST_SLAR_NACK: begin
                res.set_stop  = 1'b1;
                res.set_start = 1'b1;
              end
              default: res.set_start = 1'b1;
            endcase
            byte_index_nxt = PTR_W'(idx_after);
            if (idx_after >= eff_len) begin
              res.done_res = 1'b1;
              res.outcome  = OUTCOME_OK;
              busy_nxt     = 1'b0;
            end
          end
        end
      end
      default: begin
        if (busy_r) begin
          if (ticks_left_r <= 16'd1) begin
            ticks_left_nxt = '0;
            res.done_res   = 1'b1;
            res.outcome    = OUTCOME_TIMEOUT;
            busy_nxt       = 1'b0;
          end else begin
            ticks_left_nxt = ticks_left_r - 16'd1;
          end
        end
      end
    endcase
    if (!in_accept) begin
      busy_nxt       = busy_r;
      byte_index_nxt = byte_index_r;
      load_ptr_nxt   = load_ptr_r;
      ticks_left_nxt = ticks_left_r;
      load_we        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      byte_index_r <= '0;
      load_ptr_r   <= '0;
      ticks_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      byte_index_r <= byte_index_nxt;
      load_ptr_r   <= load_ptr_nxt;
      ticks_left_r <= ticks_left_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

  // write buffer, read port prefetches the entry at the next byte index
  assign wr_addr = load_ptr_r[ADDR_W-1:0];
  assign rd_addr = byte_index_nxt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (load_we) begin
      wbuf[wr_addr] <= in_data.data_byte;
    end
    if (load_we && (wr_addr == rd_addr)) begin
      rd_data_r <= in_data.data_byte;
    end else begin
      rd_data_r <= wbuf[rd_addr];
    end
  end

  `AST_CHK(a_done_outcome, clk, rst_n, out_valid_r && out_data_r.done_res |-> (out_data_r.outcome == OUTCOME_OK || out_data_r.outcome == OUTCOME_TIMEOUT), "done without outcome")
  `AST_CHK(a_done_idle, clk, rst_n, in_accept && res.done_res |=> !busy_r, "busy after transfer done")
  `AST_CHK(a_load_ptr_range, clk, rst_n, load_ptr_r <= PTR_W'(MAX_LENGTH), "load pointer out of range")
  `AST_CHK(a_index_range, clk, rst_n, byte_index_r <= PTR_W'(MAX_LENGTH), "byte index out of range")

endmodule
